// File: rtl/core/fmfc_pkg.sv
// shared types, constants and helper functions for the fix message frame checker
// no dependencies
package fmfc_pkg;

  // largest body length that a message may declare
  localparam int MAX_BODY_BYTES = 65536;
  // body length register holds one more than the maximum (saturation mark)
  localparam int LEN_W = $clog2(MAX_BODY_BYTES + 2);
  localparam logic [LEN_W-1:0] BLEN_MAX = LEN_W'(MAX_BODY_BYTES);
  localparam logic [LEN_W-1:0] BLEN_CAP = LEN_W'(MAX_BODY_BYTES + 1);

  // queue between classifier and parser
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // characters
  localparam logic [7:0] CH_SOH  = 8'h01;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_FOUR = 8'h34;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_EQ   = 8'h3D;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_HEADER   = 3'd1;
  localparam logic [2:0] ST_FORMAT   = 3'd2;
  localparam logic [2:0] ST_LENGTH   = 3'd3;
  localparam logic [2:0] ST_CHECKSUM = 3'd4;
  localparam logic [2:0] ST_TYPE     = 3'd5;
  localparam logic [2:0] ST_DUP      = 3'd6;
  localparam logic [2:0] ST_GAP      = 3'd7;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  msg_type;
    logic [31:0] seq_num;
    logic [16:0] msg_length;
    logic [31:0] expected_seq;
  } out_t;

  // classified byte passed from front to back
  typedef struct packed {
    logic       mode;
    logic [7:0] data;
    logic       soh;
    logic       digit;
    logic       eq;
    logic       is_8;
    logic       is_9;
    logic       is_1;
    logic       is_0;
    logic [3:0] dval;
  } cls_t;

  // decimal accumulate, saturating at all ones
  function automatic logic [31:0] dec32(logic [31:0] acc, logic [3:0] d);
    logic [35:0] t;
    t = {4'b0, acc} * 36'd10 + {32'b0, d};
    return (t > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
  endfunction

  function automatic logic [15:0] dec16(logic [15:0] acc, logic [3:0] d);
    logic [19:0] t;
    t = {4'b0, acc} * 20'd10 + {16'b0, d};
    return (t > 20'h0FFFF) ? 16'hFFFF : t[15:0];
  endfunction

  function automatic logic [LEN_W-1:0] declen(logic [LEN_W-1:0] acc, logic [3:0] d);
    logic [LEN_W+3:0] t;
    t = {4'b0, acc} * (LEN_W+4)'(10) + (LEN_W+4)'(d);
    return (t > {4'b0, BLEN_CAP}) ? BLEN_CAP : t[LEN_W-1:0];
  endfunction

  // allowed message types
  function automatic logic known_type(logic [7:0] c);
    return (c >= CH_ZERO && c <= 8'h35) || c == CH_EIGHT || c == 8'h41 ||
           c == 8'h44 || c == 8'h46 || c == 8'h47 || c == 8'h57;
  endfunction

endpackage

// File: rtl/core/fmfc_front.sv
// front end: accepts input items and classifies each byte
// depends on fmfc_pkg
module fmfc_front (
  input  logic          push,
  input  fmfc_pkg::in_t din,
  input  logic          q_full,
  output logic          wr_en,
  output fmfc_pkg::cls_t wr_data
);
  import fmfc_pkg::*;

  // accept when the queue has room
  assign wr_en = push && !q_full;

  // byte classification
  always_comb begin
    wr_data.mode  = din.mode;
    wr_data.data  = din.data_byte;
    wr_data.soh   = (din.data_byte == CH_SOH);
    wr_data.digit = (din.data_byte >= CH_ZERO) && (din.data_byte <= CH_NINE);
    wr_data.eq    = (din.data_byte == CH_EQ);
    wr_data.is_8  = (din.data_byte == CH_EIGHT);
    wr_data.is_9  = (din.data_byte == CH_NINE);
    wr_data.is_1  = (din.data_byte == CH_ONE);
    wr_data.is_0  = (din.data_byte == CH_ZERO);
    wr_data.dval  = 4'(din.data_byte - CH_ZERO);
  end

endmodule

// File: rtl/core/fmfc_queue.sv
// short queue of classified bytes between front and back
// depends on fmfc_pkg
module fmfc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  fmfc_pkg::cls_t wr_data,
  input  logic           rd_en,
  output fmfc_pkg::cls_t rd_data,
  output logic           q_full,
  output logic           q_empty
);
  import fmfc_pkg::*;

  cls_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign q_full  = (count == (QPTR_W+1)'(QDEPTH));
  assign q_empty = (count == '0);
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      if (wr_en && !rd_en) count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

endmodule

// File: rtl/core/fmfc_back.sv
// back end: message parser, sequence tracking and result register
// depends on fmfc_pkg
module fmfc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  fmfc_pkg::cls_t rd_data,
  output logic           rd_en,
  input  logic           pop,
  output logic           empty,
  output fmfc_pkg::out_t dout
);
  import fmfc_pkg::*;

  localparam logic [3:0] PH_HUNT_8    = 4'd0;
  localparam logic [3:0] PH_HUNT_EQ   = 4'd1;
  localparam logic [3:0] PH_HUNT_SOH  = 4'd2;
  localparam logic [3:0] PH_START     = 4'd3;
  localparam logic [3:0] PH_START_EQ  = 4'd4;
  localparam logic [3:0] PH_BEGIN_VAL = 4'd5;
  localparam logic [3:0] PH_TAG9      = 4'd6;
  localparam logic [3:0] PH_TAG9_EQ   = 4'd7;
  localparam logic [3:0] PH_LEN       = 4'd8;
  localparam logic [3:0] PH_BODY      = 4'd9;
  localparam logic [3:0] PH_CS1       = 4'd10;
  localparam logic [3:0] PH_CS0       = 4'd11;
  localparam logic [3:0] PH_CSEQ      = 4'd12;
  localparam logic [3:0] PH_CSVAL     = 4'd13;

  localparam logic [1:0] BS_GAP  = 2'd0;
  localparam logic [1:0] BS_TAG  = 2'd1;
  localparam logic [1:0] BS_VAL  = 2'd2;
  localparam logic [1:0] BS_DEAD = 2'd3;

  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_TYPE = 2'd1;
  localparam logic [1:0] K_SEQ  = 2'd2;
  localparam logic [1:0] K_NEW  = 2'd3;

  localparam logic [16:0] LEN_SAT = 17'h1FFFF;

  logic [3:0]       phase, phase_next;
  logic [7:0]       byte_sum, byte_sum_next;
  logic [7:0]       declared_sum, declared_sum_next;
  logic [LEN_W-1:0] body_length, body_length_next;
  logic [LEN_W-1:0] body_count, body_count_next;
  logic [15:0]      tag_value, tag_value_next;
  logic             field_seen, field_seen_next;
  logic [7:0]       type_char, type_char_next;
  logic [31:0]      seq_accum, seq_accum_next;
  logic [31:0]      new_seq_accum, new_seq_accum_next;
  logic [2:0]       error_latch, error_latch_next;
  logic [16:0]      length_count, length_count_next;
  logic [31:0]      next_seq, next_seq_next;
  logic [1:0]       body_state, body_state_next;
  logic [1:0]       value_kind, value_kind_next;
  logic             type_first, type_first_next;
  logic             digits_on, digits_on_next;
  logic             new_seen, new_seen_next;

  logic             emit;
  logic [2:0]       est;
  logic             out_valid;
  cls_t             c;

  assign c     = rd_data;
  assign rd_en = !q_empty && (!out_valid || pop);
  assign empty = !out_valid;

  // parser next state
  always_comb begin
    phase_next         = phase;
    byte_sum_next      = byte_sum;
    declared_sum_next  = declared_sum;
    body_length_next   = body_length;
    body_count_next    = body_count;
    tag_value_next     = tag_value;
    field_seen_next    = field_seen;
    type_char_next     = type_char;
    seq_accum_next     = seq_accum;
    new_seq_accum_next = new_seq_accum;
    error_latch_next   = error_latch;
    length_count_next  = length_count;
    next_seq_next      = next_seq;
    body_state_next    = body_state;
    value_kind_next    = value_kind;
    type_first_next    = type_first;
    digits_on_next     = digits_on;
    new_seen_next      = new_seen;
    emit = 1'b0;
    est  = ST_OK;

    // message clear on header start
    if (!c.mode && ((phase == PH_HUNT_EQ && c.eq) || phase == PH_START)) begin
      byte_sum_next = 8'h00; declared_sum_next = 8'h00;
      body_length_next = '0; body_count_next = '0; tag_value_next = '0;
      field_seen_next = 1'b0; type_char_next = 8'h00; seq_accum_next = '0;
      new_seq_accum_next = '0; error_latch_next = ST_OK; length_count_next = '0;
      body_state_next = BS_GAP; value_kind_next = K_NONE;
      type_first_next = 1'b0; digits_on_next = 1'b0; new_seen_next = 1'b0;
    end

    if (c.mode) begin
      next_seq_next = 32'd1;
    end else begin
      unique case (phase)
        PH_HUNT_8: begin
          if (c.is_8) phase_next = PH_HUNT_EQ;
          else if (!c.soh) phase_next = PH_HUNT_SOH;
        end
        PH_HUNT_EQ: begin
          if (c.eq) begin
            length_count_next = 17'd2;
            byte_sum_next = CH_EIGHT + CH_EQ;
            phase_next = PH_BEGIN_VAL;
          end else begin
            phase_next = c.soh ? PH_HUNT_8 : PH_HUNT_SOH;
          end
        end
        PH_HUNT_SOH: begin
          if (c.soh) phase_next = PH_HUNT_8;
        end
        PH_START: begin
          length_count_next = 17'd1;
          byte_sum_next = c.data;
          if (c.is_8) phase_next = PH_START_EQ;
          else begin
            emit = 1'b1; est = ST_HEADER;
          end
        end
        default: begin
          if (length_count != LEN_SAT) length_count_next = length_count + 1'b1;
          if (phase < PH_CS1) byte_sum_next = byte_sum + c.data;
          unique case (phase)
            PH_START_EQ: begin
              if (!c.eq) begin emit = 1'b1; est = ST_HEADER; end
              else phase_next = PH_BEGIN_VAL;
            end
            PH_BEGIN_VAL: begin
              if (c.soh) phase_next = PH_TAG9;
            end
            PH_TAG9: begin
              if (!c.is_9) begin emit = 1'b1; est = ST_HEADER; end
              else phase_next = PH_TAG9_EQ;
            end
            PH_TAG9_EQ: begin
              if (!c.eq) begin emit = 1'b1; est = ST_HEADER; end
              else phase_next = PH_LEN;
            end
            PH_LEN: begin
              if (c.soh) begin
                if (body_length > BLEN_MAX) begin emit = 1'b1; est = ST_LENGTH; end
                else phase_next = (body_length == '0) ? PH_CS1 : PH_BODY;
              end else if (!c.digit) begin
                emit = 1'b1; est = ST_FORMAT;
              end else begin
                body_length_next = declen(body_length, c.dval);
              end
            end
            PH_BODY: begin
              // body field scanner
              if (!(body_state == BS_GAP && c.soh)) begin
                if (body_state == BS_GAP) tag_value_next = '0;
                if (body_state == BS_GAP || body_state == BS_TAG) begin
                  if (c.eq) begin
                    if (!field_seen) begin
                      if (tag_value_next != 16'd35 && error_latch == ST_OK)
                        error_latch_next = ST_HEADER;
                      field_seen_next = 1'b1;
                    end
                    if (!field_seen && tag_value_next == 16'd35) begin
                      value_kind_next = K_TYPE; type_char_next = 8'h00;
                      type_first_next = 1'b1;
                    end else if (tag_value_next == 16'd34) begin
                      value_kind_next = K_SEQ; seq_accum_next = '0;
                      digits_on_next = 1'b1;
                    end else if (tag_value_next == 16'd36 && !new_seen) begin
                      value_kind_next = K_NEW; new_seen_next = 1'b1;
                      new_seq_accum_next = '0; digits_on_next = 1'b1;
                    end else begin
                      value_kind_next = K_NONE;
                    end
                    body_state_next = BS_VAL;
                  end else if (c.digit) begin
                    tag_value_next = dec16(tag_value_next, c.dval);
                    body_state_next = BS_TAG;
                  end else begin
                    error_latch_next = ST_FORMAT;
                    body_state_next = BS_DEAD;
                  end
                end else if (body_state == BS_VAL) begin
                  if (c.soh) body_state_next = BS_GAP;
                  else if (value_kind == K_TYPE) begin
                    if (type_first) begin
                      type_char_next = c.data; type_first_next = 1'b0;
                    end
                  end else if (value_kind == K_SEQ || value_kind == K_NEW) begin
                    if (digits_on && c.digit) begin
                      if (value_kind == K_SEQ) seq_accum_next = dec32(seq_accum, c.dval);
                      else new_seq_accum_next = dec32(new_seq_accum, c.dval);
                    end else begin
                      digits_on_next = 1'b0;
                    end
                  end
                end
              end
              body_count_next = body_count + 1'b1;
              if (body_count_next >= body_length) begin
                if (body_state_next == BS_TAG) error_latch_next = ST_FORMAT;
                phase_next = PH_CS1;
              end
            end
            PH_CS1: begin
              if (!c.is_1) begin emit = 1'b1; est = ST_LENGTH; end
              else phase_next = PH_CS0;
            end
            PH_CS0: begin
              if (!c.is_0) begin emit = 1'b1; est = ST_LENGTH; end
              else phase_next = PH_CSEQ;
            end
            PH_CSEQ: begin
              if (!c.eq) begin emit = 1'b1; est = ST_LENGTH; end
              else begin
                declared_sum_next = 8'h00;
                phase_next = PH_CSVAL;
              end
            end
            PH_CSVAL: begin
              if (c.soh) begin
                // final status, in priority order
                emit = 1'b1;
                if (byte_sum != declared_sum) est = ST_CHECKSUM;
                else if (error_latch != ST_OK) est = error_latch;
                else if (!known_type(type_char)) est = ST_TYPE;
                else if (type_char == CH_FOUR) begin
                  if (new_seq_accum != '0) next_seq_next = new_seq_accum;
                end else if (seq_accum != '0) begin
                  if (seq_accum < next_seq) est = ST_DUP;
                  else if (seq_accum > next_seq) est = ST_GAP;
                  else next_seq_next = (seq_accum == 32'hFFFF_FFFF) ? seq_accum
                                                                    : seq_accum + 1'b1;
                end
              end else begin
                declared_sum_next = 8'(declared_sum * 8'd10) + c.data - CH_ZERO;
              end
            end
            default: phase_next = PH_HUNT_8;
          endcase
        end
      endcase
      // resume after a result
      if (emit) begin
        if (est == ST_OK) phase_next = PH_START;
        else phase_next = c.soh ? PH_HUNT_8 : PH_HUNT_SOH;
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT_8;
      byte_sum <= '0; declared_sum <= '0; body_length <= '0; body_count <= '0;
      tag_value <= '0; field_seen <= 1'b0; type_char <= '0; seq_accum <= '0;
      new_seq_accum <= '0; error_latch <= ST_OK; length_count <= '0;
      next_seq <= 32'd1; body_state <= BS_GAP; value_kind <= K_NONE;
      type_first <= 1'b0; digits_on <= 1'b0; new_seen <= 1'b0;
    end else if (rd_en) begin
      phase <= phase_next;
      byte_sum <= byte_sum_next; declared_sum <= declared_sum_next;
      body_length <= body_length_next; body_count <= body_count_next;
      tag_value <= tag_value_next; field_seen <= field_seen_next;
      type_char <= type_char_next; seq_accum <= seq_accum_next;
      new_seq_accum <= new_seq_accum_next; error_latch <= error_latch_next;
      length_count <= length_count_next; next_seq <= next_seq_next;
      body_state <= body_state_next; value_kind <= value_kind_next;
      type_first <= type_first_next; digits_on <= digits_on_next;
      new_seen <= new_seen_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_en && emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en && emit) begin
      dout.status       <= est;
      dout.msg_type     <= type_char_next;
      dout.seq_num      <= seq_accum_next;
      dout.msg_length   <= length_count_next;
      dout.expected_seq <= next_seq_next;
    end
  end

endmodule

// File: rtl/core/fix_message_frame_checker.sv
// top level of the fix message frame checker
// depends on fmfc_pkg, fmfc_front, fmfc_queue, fmfc_back

// Checks a FIX byte stream, one byte per item, and gives one status per message
// (header, body length, checksum, message type and sequence number checks). Each
// byte is classified on entry and written to a four-entry queue; the parser behind
// it takes one byte per clock unless a result waits unpopped, so the sustained
// rate is one item per cycle while results are popped. A result waits in a
// one-entry output register; while it is not taken the parser holds and the
// queue absorbs up to four further items before full rises. A causing byte passes
// through the queue entry and then the result register to the output ports. A
// mode 1 item resets the expected sequence number to one in stream order.
module fix_message_frame_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  fmfc_pkg::in_t  din,
  output logic           empty,
  input  logic           pop,
  output fmfc_pkg::out_t dout
);
  import fmfc_pkg::*;

  logic q_wr_en;
  logic q_rd_en;
  logic q_empty;
  cls_t q_wr_data;
  cls_t q_rd_data;

  // byte classifier
  fmfc_front u_front (
    .push    (push),
    .din     (din),
    .q_full  (full),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data)
  );

  // decoupling queue
  fmfc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .q_full  (full),
    .q_empty (q_empty)
  );

  // parser and result register
  fmfc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .rd_data (q_rd_data),
    .rd_en   (q_rd_en),
    .pop     (pop),
    .empty   (empty),
    .dout    (dout)
  );

`ifndef SYNTHESIS
  // nothing waits and the queue has room right after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("outputs not clear after reset");

  // a held result keeps its contents
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(dout)))
    else $error("waiting result changed");

  // queue cannot read while empty
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    !(q_rd_en && q_empty))
    else $error("queue read while empty");
`endif

endmodule

// File: bench/fix_message_frame_checker_tb.sv
// testbench for the fix message frame checker: directed table, then random messages
// depends on fmfc_pkg and fix_message_frame_checker
module fix_message_frame_checker_tb;
  import fmfc_pkg::*;

  localparam logic [3:0] P_HUNT_8 = 4'd0, P_HUNT_EQ = 4'd1, P_HUNT_SOH = 4'd2,
    P_START = 4'd3, P_START_EQ = 4'd4, P_BEGIN_VAL = 4'd5, P_TAG9 = 4'd6,
    P_TAG9_EQ = 4'd7, P_LEN = 4'd8, P_BODY = 4'd9, P_CS1 = 4'd10, P_CS0 = 4'd11,
    P_CSEQ = 4'd12, P_CSVAL = 4'd13;
  localparam logic [1:0] B_GAP = 2'd0, B_TAG = 2'd1, B_VAL = 2'd2, B_DEAD = 2'd3;
  localparam logic [1:0] K_NONE = 2'd0, K_TYPE = 2'd1, K_SEQ = 2'd2, K_NEW = 2'd3;
  localparam logic [16:0] LEN_SAT = 17'h1FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  in_t din = '0;
  out_t dout;

  fix_message_frame_checker DUT (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .din(din), .empty(empty), .pop(pop), .dout(dout)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // frame parser shadow state
  logic [3:0] ph;
  logic [7:0] sum_acc, sum_decl, type_ch;
  logic [31:0] body_len, body_cnt, seq_acc, newseq_acc, nseq;
  logic [16:0] tag_acc;
  logic first_done, type_first, digits_on, new_seen;
  logic [2:0] err_lat;
  logic [16:0] len_cnt;
  logic [1:0] bstate, vkind;

  out_t status_q[$];
  // stream index of the byte that caused each expected result
  int idx_q[$];
  int cur_idx = -1;
  int errors = 0;
  int send_idle = 0;
  logic done_sending = 1'b0;

  task automatic report(input string what, input out_t got, input out_t want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  function automatic logic isdig(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic logic [31:0] acc10(logic [31:0] a, logic [7:0] b, logic [31:0] cap);
    logic [63:0] t;
    t = {32'b0, a} * 64'd10 + 64'(b - CH_ZERO);
    return (t > {32'b0, cap}) ? cap : t[31:0];
  endfunction

  function automatic logic allowed_type(logic [7:0] c);
    return (c >= "0" && c <= "5") || c == "8" || c == "A" || c == "D" ||
           c == "F" || c == "G" || c == "W";
  endfunction

  task automatic clear_frame();
    sum_acc = 0; sum_decl = 0; body_len = 0; body_cnt = 0; tag_acc = 0;
    first_done = 0; type_ch = 0; seq_acc = 0; newseq_acc = 0; err_lat = 0;
    len_cnt = 0; bstate = B_GAP; vkind = K_NONE; type_first = 0;
    digits_on = 0; new_seen = 0;
  endtask

  task automatic frame_reset();
    clear_frame();
    ph = P_HUNT_8;
    nseq = 1;
  endtask

  task automatic post_status(input logic [2:0] st, input logic [7:0] b);
    out_t r;
    r.status = st; r.msg_type = type_ch; r.seq_num = seq_acc;
    r.msg_length = len_cnt; r.expected_seq = nseq;
    status_q.push_back(r);
    idx_q.push_back(cur_idx);
    if (st == ST_OK) ph = P_START;
    else ph = (b == CH_SOH) ? P_HUNT_8 : P_HUNT_SOH;
  endtask

  function automatic logic [2:0] close_status();
    if (sum_acc != sum_decl) return ST_CHECKSUM;
    if (err_lat != 0) return err_lat;
    if (!allowed_type(type_ch)) return ST_TYPE;
    if (type_ch == CH_FOUR) begin
      if (newseq_acc > 0) nseq = newseq_acc;
      return ST_OK;
    end
    if (seq_acc > 0) begin
      if (seq_acc < nseq) return ST_DUP;
      if (seq_acc > nseq) return ST_GAP;
      nseq = (seq_acc == 32'hFFFF_FFFF) ? seq_acc : seq_acc + 1;
    end
    return ST_OK;
  endfunction

  task automatic tag_done();
    logic is_first;
    is_first = !first_done;
    if (is_first) begin
      if (tag_acc != 35 && err_lat == 0) err_lat = ST_HEADER;
      first_done = 1;
    end
    if (is_first && tag_acc == 35) begin
      vkind = K_TYPE; type_ch = 0; type_first = 1;
    end else if (tag_acc == 34) begin
      vkind = K_SEQ; seq_acc = 0; digits_on = 1;
    end else if (tag_acc == 36 && !new_seen) begin
      vkind = K_NEW; new_seen = 1; newseq_acc = 0; digits_on = 1;
    end else vkind = K_NONE;
    bstate = B_VAL;
  endtask

  task automatic body_step(input logic [7:0] b);
    if (bstate == B_GAP) begin
      if (b == CH_SOH) return;
      bstate = B_TAG; tag_acc = 0;
    end
    if (bstate == B_TAG) begin
      if (b == CH_EQ) tag_done();
      else if (isdig(b)) tag_acc = 17'(acc10(32'(tag_acc), b, 32'd65535));
      else begin err_lat = ST_FORMAT; bstate = B_DEAD; end
    end else if (bstate == B_VAL) begin
      if (b == CH_SOH) begin bstate = B_GAP; return; end
      if (vkind == K_TYPE) begin
        if (type_first) begin type_ch = b; type_first = 0; end
      end else if (vkind == K_SEQ || vkind == K_NEW) begin
        if (digits_on && isdig(b)) begin
          if (vkind == K_SEQ) seq_acc = acc10(seq_acc, b, 32'hFFFF_FFFF);
          else newseq_acc = acc10(newseq_acc, b, 32'hFFFF_FFFF);
        end else digits_on = 0;
      end
    end
  endtask

  // predict the status, if any, caused by one item
  task automatic frame_step(input in_t it);
    logic [7:0] b;
    b = it.data_byte;
    if (it.mode) begin nseq = 1; return; end
    case (ph)
      P_HUNT_8: begin
        if (b == CH_EIGHT) ph = P_HUNT_EQ;
        else if (b != CH_SOH) ph = P_HUNT_SOH;
        return;
      end
      P_HUNT_EQ: begin
        if (b == CH_EQ) begin
          clear_frame(); len_cnt = 2; sum_acc = CH_EIGHT + CH_EQ; ph = P_BEGIN_VAL;
        end else ph = (b == CH_SOH) ? P_HUNT_8 : P_HUNT_SOH;
        return;
      end
      P_HUNT_SOH: begin
        if (b == CH_SOH) ph = P_HUNT_8;
        return;
      end
      P_START: begin
        clear_frame(); len_cnt = 1; sum_acc = b;
        if (b == CH_EIGHT) ph = P_START_EQ;
        else post_status(ST_HEADER, b);
        return;
      end
      default: ;
    endcase
    if (len_cnt < LEN_SAT) len_cnt++;
    if (ph < P_CS1) sum_acc = sum_acc + b;
    case (ph)
      P_START_EQ: if (b != CH_EQ) post_status(ST_HEADER, b); else ph = P_BEGIN_VAL;
      P_BEGIN_VAL: if (b == CH_SOH) ph = P_TAG9;
      P_TAG9: if (b != CH_NINE) post_status(ST_HEADER, b); else ph = P_TAG9_EQ;
      P_TAG9_EQ: if (b != CH_EQ) post_status(ST_HEADER, b); else ph = P_LEN;
      P_LEN: begin
        if (b == CH_SOH) begin
          if (body_len > MAX_BODY_BYTES) post_status(ST_LENGTH, b);
          else ph = (body_len == 0) ? P_CS1 : P_BODY;
        end else if (!isdig(b)) post_status(ST_FORMAT, b);
        else body_len = acc10(body_len, b, MAX_BODY_BYTES + 1);
      end
      P_BODY: begin
        body_step(b);
        body_cnt++;
        if (body_cnt >= body_len) begin
          if (bstate == B_TAG) err_lat = ST_FORMAT;
          ph = P_CS1;
        end
      end
      P_CS1: if (b != CH_ONE) post_status(ST_LENGTH, b); else ph = P_CS0;
      P_CS0: if (b != CH_ZERO) post_status(ST_LENGTH, b); else ph = P_CSEQ;
      P_CSEQ: begin
        if (b != CH_EQ) post_status(ST_LENGTH, b);
        else begin sum_decl = 0; ph = P_CSVAL; end
      end
      P_CSVAL: begin
        if (b == CH_SOH) post_status(close_status(), b);
        else sum_decl = 8'(sum_decl * 10 + b - CH_ZERO);
      end
      default: ph = P_HUNT_8;
    endcase
  endtask

  // items to send: byte stream built up front
  in_t stream[$];
  // directed table: text of each row, and a typed status where it is obvious
  string dir_text[$];
  int dir_row_end[$];
  out_t dir_row_want[$];
  logic dir_row_has[$];

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) stream.push_back({1'b0, 8'(s[i])});
  endtask

  task automatic add_row(input string s, input logic has, input logic [2:0] st);
    out_t w;
    w = '0;
    w.status = st;
    dir_text.push_back(s);
    dir_row_has.push_back(has);
    dir_row_want.push_back(w);
  endtask

  // build a well formed message, with optional corruption
  task automatic add_msg(input logic [7:0] mtype, input logic [31:0] seq,
                         input int pad, input int flaw);
    string body, full_s, tmp;
    logic [7:0] cs;
    int blen;
    body = $sformatf("35=%s\001", string'(mtype));
    if (mtype == CH_FOUR) body = {body, $sformatf("36=%0d\001", seq)};
    else if (seq != 0) body = {body, $sformatf("34=%0d\001", seq)};
    for (int i = 0; i < pad; i++) begin
      tmp = $sformatf("%0d=", $urandom_range(1, 999));
      for (int j = $urandom_range(0, 4); j > 0; j--)
        tmp = {tmp, string'(8'($urandom_range(32, 126)))};
      body = {body, tmp, "\001"};
    end
    blen = body.len();
    if (flaw == 1) blen = blen + $urandom_range(0, 1) * 2 - 1;
    full_s = {"8=FIX.4.4\0019=", $sformatf("%0d", blen), "\001", body};
    cs = 0;
    for (int i = 0; i < full_s.len(); i++) cs = cs + 8'(full_s[i]);
    if (flaw == 2) cs = cs + 1;
    if (flaw == 3) begin
      full_s[$urandom_range(0, full_s.len() - 1)] = 8'($urandom);
    end
    add_str({full_s, "10=", $sformatf("%03d", cs), "\001"});
  endtask

  // a plausible next sequence number for random messages
  function automatic logic [31:0] nseq_guess();
    return $urandom_range(0, 1) ? 32'($urandom_range(1, 40)) : 32'd0;
  endfunction

  // item driver
  initial begin
    int k, phase_sel;
    logic [7:0] types[14];
    types = '{"0","1","2","3","4","5","8","A","D","F","G","W","Z","x"};
    // directed table
    add_row({"8=A\0019=0\00110=",
             $sformatf("%03d", 8'("8"+"="+"A"+1+"9"+"="+"0"+1)), "\001"},
            1'b1, ST_TYPE);                            // empty body, no type tag
    add_row("X", 1'b0, ST_OK);                         // stray byte while hunting
    add_row("\0018=A\0019=1x", 1'b1, ST_FORMAT);       // bad length digit
    add_row("\0018=A\0019=999999\001", 1'b1, ST_LENGTH); // oversize length
    for (int r = 0; r < dir_text.size(); r++) begin
      add_str(dir_text[r]);
      dir_row_end.push_back(stream.size() - 1);
    end
    stream.push_back({1'b1, 8'hFF});     // sequence reset
    stream.push_back({1'b0, 8'h00});
    stream.push_back({1'b0, 8'hFF});
    stream.push_back({1'b0, 8'h01});
    add_msg("A", 1, 0, 0);
    add_msg("D", 1, 0, 0);               // duplicate
    add_msg("D", 5, 0, 0);               // gap
    add_msg("4", 32'hFFFF_FFFF, 0, 0);   // sequence reset to saturation
    add_msg("0", 32'hFFFF_FFFF, 0, 0);
    add_msg("Z", 0, 1, 0);               // unknown type
    add_msg("1", 0, 0, 2);               // checksum
    add_msg("1", 0, 0, 1);               // misplaced trailer
    // random part
    while (stream.size() < 1950) begin
      k = $urandom_range(0, 99);
      if (k < 3) stream.push_back({1'b1, 8'($urandom)});
      else if (k < 10) stream.push_back({1'b0, 8'($urandom)});
      else if (k < 12) begin
        stream.push_back({1'b1, 8'h00});
      end else
        add_msg(types[$urandom_range(0, 13)],
                ($urandom_range(0, 3) == 0) ? $urandom : nseq_guess(),
                $urandom_range(0, 3), ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
    end
    frame_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    k = 0;
    while (k < stream.size()) begin
      phase_sel = (k * 4) / stream.size();
      if ((phase_sel == 1 && $urandom_range(0, 99) < 86) ||
          (phase_sel == 3 && $urandom_range(0, 99) < 7)) begin
        push <= 1'b0;
        @(posedge clk);
      end else begin
        push <= 1'b1;
        din <= stream[k];
        @(posedge clk);
        while (full) @(posedge clk);
        cur_idx = k;
        frame_step(stream[k]);
        k++;
        if (k == stream.size()) push <= 1'b0;
      end
      send_idle = phase_sel;
    end
    push <= 1'b0;
    done_sending = 1'b1;
  end

  // receiver: stall pattern follows the sender's phase, with one long hold
  initial begin
    int held;
    held = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (held == 0 && send_idle == 0 && status_q.size() > 0) begin
        pop <= 1'b0;
        repeat (200) @(posedge clk);
        held = 1;
      end else if ((send_idle == 2 && $urandom_range(0, 99) < 86) ||
                   (send_idle == 3 && $urandom_range(0, 99) < 7))
        pop <= 1'b0;
      else
        pop <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    out_t want;
    int at;
    if (!rst && pop && !empty) begin
      if (status_q.size() == 0) report("unexpected item", dout, '0);
      else begin
        want = status_q.pop_front();
        at = idx_q.pop_front();
        if (dout.status !== want.status) report("status", dout, want);
        else if (dout.msg_type !== want.msg_type) report("msg_type", dout, want);
        else if (dout.seq_num !== want.seq_num) report("seq_num", dout, want);
        else if (dout.msg_length !== want.msg_length) report("msg_length", dout, want);
        else if (dout.expected_seq !== want.expected_seq) report("expected_seq", dout, want);
        // typed status of directed rows
        for (int r = 0; r < dir_row_end.size(); r++)
          if (dir_row_has[r] && dir_row_end[r] == at &&
              dout.status !== dir_row_want[r].status)
            report("directed status", dout, dir_row_want[r]);
      end
    end
  end

  // end of run
  initial begin
    wait (done_sending);
    wait (status_q.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && status_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
